/* rtl/crct_pkg.sv */
`timescale 1ns / 1ps
package crct_pkg;
  localparam int POS_BITS_DEF = 20;
  localparam int CORDIC_STEPS_DEF = 14;
  localparam int TABLE_LEN = 20;
  localparam int CW = 18;
  localparam int ZW = 18;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 18'sd9949;
  localparam int DIM_BITS = 14;
  localparam logic [0:0] REG_HALF_WIDTH = 1'b0;
  localparam logic [0:0] REG_HALF_LENGTH = 1'b1;
  localparam logic [1:0] VIEW_NONE = 2'd0;
  localparam logic [1:0] VIEW_DIRECT = 2'd1;
  localparam logic [1:0] VIEW_MIRROR = 2'd2;

  typedef struct packed {
    logic signed [POS_BITS_DEF-1:0] pos_x;
    logic signed [POS_BITS_DEF-1:0] pos_y;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic       overlap;
    logic [1:0] hit_view;
  } out_item_t;

  function automatic logic signed [ZW-1:0] atan_q14(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 18'sd12868;
      1: v = 18'sd7596;
      2: v = 18'sd4014;
      3: v = 18'sd2037;
      4: v = 18'sd1023;
      5: v = 18'sd512;
      6: v = 18'sd256;
      7: v = 18'sd128;
      8: v = 18'sd64;
      9: v = 18'sd32;
      10: v = 18'sd16;
      11: v = 18'sd8;
      12: v = 18'sd4;
      13: v = 18'sd2;
      14: v = 18'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

/* rtl/crct_cordic_cell.sv */
`timescale 1ns / 1ps
module crct_cordic_cell import crct_pkg::*; #(
  parameter int STEP = 0,
  parameter int PW = 20
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic signed [PW-1:0] px_i,
  input  logic signed [PW-1:0] py_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic signed [PW-1:0] px_o,
  output logic signed [PW-1:0] py_o
);
  logic signed [CW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;

  // one micro-rotation toward zero residual angle
  always_comb begin
    if (z_i >= 0) begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - atan_q14(STEP);
    end else begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + atan_q14(STEP);
    end
  end

  // hand to neighbor, hold while the pipe is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      x_o  <= x_nxt;
      y_o  <= y_nxt;
      z_o  <= z_nxt;
      px_o <= px_i;
      py_o <= py_i;
    end
  end
endmodule

/* rtl/crct_corner_test.sv */
`timescale 1ns / 1ps
module crct_corner_test import crct_pkg::*; #(
  parameter int PW = 20
) (
  input  logic signed [PW+1:0] px,
  input  logic signed [PW+1:0] py,
  input  logic signed [CW:0]   ls,
  input  logic signed [CW:0]   ws,
  input  logic signed [CW:0]   lc,
  input  logic signed [CW:0]   wc,
  input  logic [DIM_BITS-1:0]  w,
  input  logic [DIM_BITS-1:0]  l,
  output logic                 hit
);
  localparam int SW = PW + 5;
  logic signed [SW-1:0] xl, yl, xr, yr, sw, sl;

  // both rear corners against the base rectangle
  always_comb begin
    sw = SW'($signed({1'b0, w}));
    sl = SW'($signed({1'b0, l}));
    xl = SW'(px) - SW'(wc) + SW'(ls);
    yl = SW'(py) - SW'(lc) - SW'(ws);
    xr = SW'(px) + SW'(wc) + SW'(ls);
    yr = SW'(py) - SW'(lc) + SW'(ws);
    hit = (xl < sw && xl > -sw && yl < sl) || (xr < sw && xr > -sw && yr < sl);
  end
endmodule

/* rtl/car_rectangle_collision_test.sv */
`timescale 1ns / 1ps
// Request to result: CORDIC cell chain, stages A, B, C, output register.
// Throughput: one request per cycle; the CORDIC cell chain and the
// product/test stages are fully pipelined, stalled together by out_ready.
// Reset (rst_n low, synchronous): valids clear, half_width and half_length
// return to zero.
module car_rectangle_collision_test import crct_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [2:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);
  localparam int PW = POS_BITS_DEF;
  localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int DEPTH = NS + 4;

  logic [DIM_BITS-1:0] hw_r, hl_r;
  logic adv;
  logic [DEPTH-1:0] vld_r;

  // config registers
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
      hl_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_HALF_WIDTH) hw_r <= cfg_pwdata[DIM_BITS-1:0];
      else hl_r <= cfg_pwdata[DIM_BITS-1:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_HALF_LENGTH) cfg_prdata[DIM_BITS-1:0] = hl_r;
    else cfg_prdata[DIM_BITS-1:0] = hw_r;
  end

  // whole pipe moves when the output slot is free
  assign adv = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_valid};
  end

  // CORDIC cell chain
  logic signed [CW-1:0] cx [NS+1];
  logic signed [CW-1:0] cy [NS+1];
  logic signed [ZW-1:0] cz [NS+1];
  logic signed [PW-1:0] cpx [NS+1];
  logic signed [PW-1:0] cpy [NS+1];
  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = ZW'(in_data.angle);
  assign cpx[0] = in_data.pos_x;
  assign cpy[0] = in_data.pos_y;

  for (genvar g = 0; g < NS; g++) begin : g_cell
    crct_cordic_cell #(.STEP(g), .PW(PW)) u_cell (
      .clk(clk), .en(adv), .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]),
      .px_i(cpx[g]), .py_i(cpy[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]),
      .px_o(cpx[g+1]), .py_o(cpy[g+1])
    );
  end

  // stage A: products
  localparam int MW = PW + CW;
  logic signed [PW-1:0] px_a_r, py_a_r;
  logic signed [CW:0] wc_a_r, ws_a_r, lc_a_r, ls_a_r, wsn_a_r, lsn_a_r;
  logic signed [MW-1:0] pxc_a_r, pys_a_r, pyc_a_r, pxs_a_r;
  logic signed [CW:0] wc_nxt, ws_nxt, lc_nxt, ls_nxt, wsn_nxt, lsn_nxt;
  logic signed [CW+DIM_BITS:0] m0, m1, m2, m3;
  always_comb begin
    m0 = $signed({1'b0, hw_r}) * cx[NS];
    m1 = $signed({1'b0, hw_r}) * cy[NS];
    m2 = $signed({1'b0, hl_r}) * cx[NS];
    m3 = $signed({1'b0, hl_r}) * cy[NS];
    wc_nxt = (CW+1)'(m0 >>> 14);
    ws_nxt = (CW+1)'(m1 >>> 14);
    lc_nxt = (CW+1)'(m2 >>> 14);
    ls_nxt = (CW+1)'(m3 >>> 14);
    // negated sine products, truncated after the sign flip
    wsn_nxt = (CW+1)'((-m1) >>> 14);
    lsn_nxt = (CW+1)'((-m3) >>> 14);
  end
  always_ff @(posedge clk) if (adv) begin
    px_a_r <= cpx[NS]; py_a_r <= cpy[NS];
    wc_a_r <= wc_nxt; ws_a_r <= ws_nxt; lc_a_r <= lc_nxt; ls_a_r <= ls_nxt;
    wsn_a_r <= wsn_nxt; lsn_a_r <= lsn_nxt;
    pxc_a_r <= cpx[NS] * cx[NS];
    pys_a_r <= cpy[NS] * cy[NS];
    pyc_a_r <= cpy[NS] * cx[NS];
    pxs_a_r <= cpx[NS] * cy[NS];
  end

  // stage B: direct test, rotated position
  logic hit1_nxt;
  logic signed [PW+1:0] rx_nxt, ry_nxt;
  logic signed [MW:0] sx, sy;
  crct_corner_test #(.PW(PW)) u_t1 (
    .px((PW+2)'(px_a_r)), .py((PW+2)'(py_a_r)), .ls(ls_a_r), .ws(ws_a_r),
    .lc(lc_a_r), .wc(wc_a_r), .w(hw_r), .l(hl_r), .hit(hit1_nxt)
  );
  always_comb begin
    sx = (MW+1)'(pxc_a_r) + (MW+1)'(pys_a_r);
    sy = (MW+1)'(pyc_a_r) - (MW+1)'(pxs_a_r);
    rx_nxt = (PW+2)'(sx >>> 14);
    ry_nxt = (PW+2)'(sy >>> 14);
  end
  logic hit1_b_r;
  logic signed [PW+1:0] rx_b_r, ry_b_r;
  logic signed [CW:0] wc_b_r, ws_b_r, lc_b_r, ls_b_r;
  always_ff @(posedge clk) if (adv) begin
    hit1_b_r <= hit1_nxt;
    rx_b_r <= rx_nxt; ry_b_r <= ry_nxt;
    wc_b_r <= wc_a_r; lc_b_r <= lc_a_r;
    ws_b_r <= wsn_a_r; ls_b_r <= lsn_a_r;
  end

  // stage C: mirrored test
  logic hit2_nxt;
  crct_corner_test #(.PW(PW)) u_t2 (
    .px(rx_b_r), .py(ry_b_r), .ls(ls_b_r), .ws(ws_b_r),
    .lc(lc_b_r), .wc(wc_b_r), .w(hw_r), .l(hl_r), .hit(hit2_nxt)
  );
  logic h1_c_r, h2_c_r;
  always_ff @(posedge clk) if (adv) begin
    h1_c_r <= hit1_b_r;
    h2_c_r <= hit2_nxt;
  end

  // output register
  out_item_t res_r;
  always_ff @(posedge clk) if (adv) begin
    res_r.overlap  <= h1_c_r || h2_c_r;
    res_r.hit_view <= h1_c_r ? VIEW_DIRECT : (h2_c_r ? VIEW_MIRROR : VIEW_NONE);
  end
  assign out_data = res_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.overlap == (out_data.hit_view != VIEW_NONE)))
    else $error("overlap and view disagree");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready not tied to output slot");
endmodule
